@@ rtl/nbrp_pkg.sv @@
// Shared types, constants and state codes for the nearest-box ray pick block.
// Used by the interfaces, the divider, the sequencer and the top level.
package nbrp_pkg;

   localparam int COORD_W      = 32;
   localparam int ID_W         = 16;
   localparam int ID_BITS_DEF  = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int T_W          = 64;
   localparam int DIST_W       = 64;

   localparam logic [CSR_IDX_W-1:0] REG_ORG_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORG_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORG_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_CHOOSE,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_COORD,
      ST_SQUARE,
      ST_COMPARE,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x, min_y, min_z;
      logic signed [COORD_W-1:0] max_x, max_y, max_z;
      logic [ID_W-1:0]           box_id;
      logic                      box_enabled;
      logic                      batch_last;
   } req_word_type;

   typedef struct packed {
      logic [ID_W-1:0]           picked_id;
      logic signed [COORD_W-1:0] hit_x, hit_y, hit_z;
   } rsp_word_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > $signed({2'b00, {(COORD_W-1){1'b1}}}))
         r = {1'b0, {(COORD_W-1){1'b1}}};
      else if (v < $signed({2'b11, {(COORD_W-1){1'b0}}}))
         r = {1'b1, {(COORD_W-1){1'b0}}};
      else
         r = v[COORD_W-1:0];
      return r;
   endfunction

endpackage

@@ rtl/nbrp_if.sv @@
// Valid/ready channel interfaces for box words, pick words and register writes.
// Depends on nbrp_pkg.
interface nbrp_req_if;
   logic                  valid;
   logic                  ready;
   nbrp_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface nbrp_rsp_if;
   logic                  valid;
   logic                  ready;
   nbrp_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface nbrp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [nbrp_pkg::CSR_IDX_W-1:0]      index;
   logic [nbrp_pkg::COORD_W-1:0]        wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/nearest_box_ray_pick.sv @@
// Top level of the nearest-box ray pick: ray registers, sequencer, shared divider.
// Depends on nbrp_pkg, nbrp_if, nbrp_div and nbrp_seq.
//
// Usage: write the ray origin (indexes 0..2) and direction (3..5), signed Q16.16,
// over the csr channel while idle. Then send one box word per box on req; the
// word with batch_last set closes the batch and yields one pick word on rsp:
// the nearest hit box id (0 if none) and its hit point, else origin+direction.
// Throughput: one box at a time. A disabled box or a box with the origin inside
// needs no divide; any other box runs one divide per valid axis on the 64-step
// restoring divider, shared by the three axes.
// The pick word is registered as the last box finishes and sits in an
// output register, so the next batch may start while it waits. A closing box
// finishing while an earlier pick word is still untaken waits until it is taken.
// Reset (synchronous, active high) clears the ray to zero and empties the
// output register; csr is always ready.
module nearest_box_ray_pick #(
   parameter int ID_BITS = nbrp_pkg::ID_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   nbrp_req_if.sink    req,
   nbrp_rsp_if.source  rsp,
   nbrp_csr_if.sink    csr
);
   import nbrp_pkg::*;

   logic signed [COORD_W-1:0] org_ff [3];
   logic signed [COORD_W-1:0] dir_ff [3];
   logic                      busy, div_start;
   logic [T_W-1:0]            div_dividend, div_quotient;
   logic [COORD_W:0]          div_divisor;
   div_ctl_type               div_ctl;

   // Ray registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            dir_ff[i] <= '0;
         end
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_ORG_X: org_ff[0] <= csr.wdata;
            REG_ORG_Y: org_ff[1] <= csr.wdata;
            REG_ORG_Z: org_ff[2] <= csr.wdata;
            REG_DIR_X: dir_ff[0] <= csr.wdata;
            REG_DIR_Y: dir_ff[1] <= csr.wdata;
            REG_DIR_Z: dir_ff[2] <= csr.wdata;
            default: ;
         endcase
      end
   end
   assign csr.ready = 1'b1;
   assign req.ready = !busy;

   nbrp_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .quotient(div_quotient), .ctl(div_ctl)
   );

   nbrp_seq #(.ID_BITS(ID_BITS)) u_seq (
      .clock(clock), .reset(reset),
      .req_fire(req.valid && !busy), .req_word(req.data),
      .org(org_ff), .dir(dir_ff),
      .rsp_take(rsp.valid && rsp.ready),
      .busy(busy), .rsp_valid(rsp.valid), .rsp_word(rsp.data),
      .div_start(div_start), .div_dividend(div_dividend), .div_divisor(div_divisor),
      .div_quotient(div_quotient), .div_ctl(div_ctl)
   );
endmodule

@@ rtl/nbrp_div.sv @@
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 33-bit divisor.
// Depends on nbrp_pkg.
module nbrp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nbrp_pkg::T_W-1:0]   dividend,
   input  logic [nbrp_pkg::COORD_W:0] divisor,
   output logic [nbrp_pkg::T_W-1:0]   quotient,
   output nbrp_pkg::div_ctl_type      ctl
);
   import nbrp_pkg::*;

   localparam int CNT_W = $clog2(T_W + 1);

   logic [T_W-1:0]     quo_ff, quo_in;
   logic [COORD_W+1:0] rem_ff, rem_in;
   logic [COORD_W:0]   dsr_ff, dsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [COORD_W+1:0] trial;

   // One shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[COORD_W:0], quo_ff[T_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(T_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[T_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[T_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
endmodule

@@ rtl/nbrp_seq.sv @@
// Sequencer for one box: classify, up to three divides, scale, square, compare.
// Depends on nbrp_pkg and nbrp_div (instantiated by the top level).
module nbrp_seq #(
   parameter int ID_BITS = nbrp_pkg::ID_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_fire,
   input  nbrp_pkg::req_word_type            req_word,
   input  logic signed [nbrp_pkg::COORD_W-1:0] org [3],
   input  logic signed [nbrp_pkg::COORD_W-1:0] dir [3],
   input  logic                              rsp_take,
   output logic                              busy,
   output logic                              rsp_valid,
   output nbrp_pkg::rsp_word_type            rsp_word,
   output logic                              div_start,
   output logic [nbrp_pkg::T_W-1:0]          div_dividend,
   output logic [nbrp_pkg::COORD_W:0]        div_divisor,
   input  logic [nbrp_pkg::T_W-1:0]          div_quotient,
   input  nbrp_pkg::div_ctl_type             div_ctl
);
   import nbrp_pkg::*;

   localparam logic [T_W-1:0] OFFSET_LIMIT = 64'h2_0000_0000;

   seq_state_type state_ff, state_in;

   req_word_type          box_ff, box_in;
   logic [1:0]            ax_ff, ax_in;
   logic [2:0]            left_ff, left_in, right_ff, right_in, valid_ff, valid_in;
   logic signed [COORD_W:0] num_ff [3];
   logic signed [COORD_W:0] num_in [3];
   logic [T_W-1:0]        t_ff [3];
   logic [T_W-1:0]        t_in [3];
   logic [1:0]            w_ff, w_in;
   logic [T_W-1:0]        acc_ff, acc_in;
   logic signed [COORD_W-1:0] pt_ff [3];
   logic signed [COORD_W-1:0] pt_in [3];
   logic [DIST_W-1:0]     dsum_ff, dsum_in, best_d_ff, best_d_in;
   logic [ID_W-1:0]       best_id_ff, best_id_in;
   logic signed [COORD_W-1:0] best_pt_ff [3];
   logic signed [COORD_W-1:0] best_pt_in [3];
   logic                  open_ff, open_in;
   logic                  rv_ff, rv_in;
   rsp_word_type          rw_ff, rw_in;

   // Shared multiplier operands
   logic [COORD_W:0]      mul_a, mul_b;
   logic [2*COORD_W+1:0]  mul_p;
   logic signed [COORD_W-1:0] bmin, bmax, o, d;
   logic signed [COORD_W+2:0] cval;
   logic [T_W:0]          sum_w;
   logic [DIST_W-1:0]     sq;
   logic [COORD_W:0]      dmag;
   logic signed [COORD_W:0] dif;
   logic [T_W-1:0]        sc;

   assign mul_p = mul_a * mul_b;

   function automatic logic [COORD_W:0] mag(input logic signed [COORD_W:0] v);
      return v[COORD_W] ? (COORD_W+1)'(-v) : v;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         open_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         rv_ff    <= rv_in;
      end
      box_ff <= box_in; ax_ff <= ax_in; left_ff <= left_in; right_ff <= right_in;
      valid_ff <= valid_in; w_ff <= w_in; acc_ff <= acc_in;
      dsum_ff <= dsum_in; best_d_ff <= best_d_in; best_id_ff <= best_id_in;
      rw_ff <= rw_in;
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= num_in[i];
         t_ff[i] <= t_in[i];
         pt_ff[i] <= pt_in[i];
         best_pt_ff[i] <= best_pt_in[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      box_in = box_ff; ax_in = ax_ff; left_in = left_ff; right_in = right_ff;
      valid_in = valid_ff; w_in = w_ff; acc_in = acc_ff;
      dsum_in = dsum_ff; best_d_in = best_d_ff; best_id_in = best_id_ff;
      open_in = open_ff; rv_in = rv_ff; rw_in = rw_ff;
      num_in = num_ff; t_in = t_ff; pt_in = pt_ff; best_pt_in = best_pt_ff;
      div_start = 1'b0;
      div_dividend = '0;
      div_divisor = '0;
      mul_a = '0; mul_b = '0;
      cval = '0; sum_w = '0; sq = '0; dif = '0; sc = '0;
      bmin = '0; bmax = '0;
      o = org[ax_ff]; d = dir[ax_ff];
      dmag = mag({d[COORD_W-1], d});
      unique case (ax_ff)
         2'd0: begin bmin = box_ff.min_x; bmax = box_ff.max_x; end
         2'd1: begin bmin = box_ff.min_y; bmax = box_ff.max_y; end
         default: begin bmin = box_ff.min_z; bmax = box_ff.max_z; end
      endcase

      if (rsp_take) rv_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               box_in = req_word;
               ax_in = 2'd0;
               left_in = '0; right_in = '0; valid_in = '0;
               if (!open_ff) begin
                  open_in = 1'b1;
                  best_d_in = '1;
                  best_id_in = '0;
                  for (int i = 0; i < 3; i++)
                     best_pt_in[i] = sat32($signed({org[i][COORD_W-1], org[i]})
                                         + $signed({dir[i][COORD_W-1], dir[i]}));
               end
               state_in = req_word.box_enabled ? ST_CLASSIFY : ST_DONE;
            end
         end
         // Candidate plane per axis, one axis a cycle
         ST_CLASSIFY: begin
            t_in[ax_ff] = '0;
            if (o < bmin) begin
               left_in[ax_ff] = 1'b1;
               num_in[ax_ff] = $signed({bmin[COORD_W-1], bmin}) - $signed({o[COORD_W-1], o});
            end else if (o > bmax) begin
               right_in[ax_ff] = 1'b1;
               num_in[ax_ff] = $signed({bmax[COORD_W-1], bmax}) - $signed({o[COORD_W-1], o});
            end
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0;
               if ((left_in | right_in) == 3'b000) begin
                  for (int i = 0; i < 3; i++) pt_in[i] = org[i];
                  dsum_in = '0;
                  state_in = ST_COMPARE;
               end else begin
                  state_in = ST_DIV_START;
               end
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_DIV_START: begin
            if ((left_ff[ax_ff] || right_ff[ax_ff]) && d != 0
                && ((num_ff[ax_ff] > 0) == (d > 0))) begin
               valid_in[ax_ff] = 1'b1;
               div_start = 1'b1;
               div_dividend = T_W'(mag(num_ff[ax_ff])) << 30;
               div_divisor = dmag;
               state_in = ST_DIV_WAIT;
            end else if (ax_ff == 2'd2) begin
               state_in = ST_CHOOSE;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_DIV_WAIT: begin
            if (div_ctl.done) begin
               t_in[ax_ff] = div_quotient;
               if (ax_ff == 2'd2) state_in = ST_CHOOSE;
               else begin
                  ax_in = ax_ff + 2'd1;
                  state_in = ST_DIV_START;
               end
            end
         end
         // Largest valid t, lower axis on ties
         ST_CHOOSE: begin
            w_in = 2'd0;
            if (valid_ff == 3'b000) state_in = ST_DONE;
            else begin
               w_in = valid_ff[0] ? 2'd0 : (valid_ff[1] ? 2'd1 : 2'd2);
               if (valid_ff[1] && (!valid_ff[0] || t_ff[0] < t_ff[1])) w_in = 2'd1;
               if (valid_ff[2] && t_ff[w_in] < t_ff[2]) w_in = 2'd2;
               ax_in = 2'd0;
               state_in = ST_SCALE_LO;
            end
         end
         ST_SCALE_LO: begin
            if (ax_ff == w_ff) begin
               pt_in[ax_ff] = left_ff[ax_ff] ? bmin : bmax;
               if (ax_ff == 2'd2) begin
                  ax_in = 2'd0; dsum_in = '0; state_in = ST_SQUARE;
               end else ax_in = ax_ff + 2'd1;
            end else begin
               mul_a = {1'b0, t_ff[w_ff][31:0]};
               mul_b = dmag;
               acc_in = T_W'(mul_p >> 30);
               state_in = ST_SCALE_HI;
            end
         end
         ST_SCALE_HI: begin
            mul_a = {1'b0, t_ff[w_ff][63:32]};
            mul_b = dmag;
            acc_in = acc_ff + (T_W'(mul_p) << 2);
            state_in = ST_COORD;
         end
         ST_COORD: begin
            sc = acc_ff;
            if (sc > OFFSET_LIMIT) begin
               state_in = ST_DONE;
            end else begin
               if (d < 0)
                  cval = $signed({{3{o[COORD_W-1]}}, o})
                       - $signed({1'b0, sc[COORD_W+1:0]});
               else
                  cval = $signed({{3{o[COORD_W-1]}}, o})
                       + $signed({1'b0, sc[COORD_W+1:0]});
               if (cval < $signed({{3{bmin[COORD_W-1]}}, bmin})
                   || cval > $signed({{3{bmax[COORD_W-1]}}, bmax})) begin
                  state_in = ST_DONE;
               end else begin
                  pt_in[ax_ff] = cval[COORD_W-1:0];
                  if (ax_ff == 2'd2) begin
                     ax_in = 2'd0; dsum_in = '0; state_in = ST_SQUARE;
                  end else begin
                     ax_in = ax_ff + 2'd1; state_in = ST_SCALE_LO;
                  end
               end
            end
         end
         // Squared distance, one axis a cycle on the shared multiplier
         ST_SQUARE: begin
            dif = $signed({pt_ff[ax_ff][COORD_W-1], pt_ff[ax_ff]})
                - $signed({o[COORD_W-1], o});
            mul_a = mag(dif);
            mul_b = mag(dif);
            sq = mul_p[DIST_W-1:0];
            sum_w = {1'b0, dsum_ff} + {1'b0, sq};
            dsum_in = sum_w[T_W] ? '1 : sum_w[T_W-1:0];
            if (ax_ff == 2'd2) state_in = ST_COMPARE;
            else ax_in = ax_ff + 2'd1;
         end
         ST_COMPARE: begin
            if (dsum_ff < best_d_ff) begin
               best_d_in = dsum_ff;
               best_id_in = ID_W'(box_ff.box_id[ID_BITS-1:0]);
               best_pt_in = pt_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (box_ff.batch_last) begin
               if (!rv_ff || rsp_take) begin
                  rv_in = 1'b1;
                  rw_in.picked_id = best_id_ff;
                  rw_in.hit_x = best_pt_ff[0];
                  rw_in.hit_y = best_pt_ff[1];
                  rw_in.hit_z = best_pt_ff[2];
                  open_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end else state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_word  = rw_ff;
endmodule

@@ rtl/nbrp_checker.sv @@
// Port-level checker for the nearest-box ray pick, bound to the top level.
// Depends on the interface ports of nearest_box_ray_pick.
module nbrp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_ready
);
   // A taken box word keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");

   // A pick word waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("pick word dropped");

   // Register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("csr stalled");

   // After reset no pick word is pending
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("pick word after reset");
endmodule

bind nearest_box_ray_pick nbrp_checker u_nbrp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .csr_ready(csr.ready)
);
